[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/bsmm_pkg.sv]
// Types and constants of the bank-switched memory mapper.
// Used by the front end, back end, top level and testbench; depends on nothing.
package bsmm_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_BANK  = 2'd2,
        CMD_ROM   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        TGT_NONE   = 2'd0,
        TGT_SYSROM = 2'd1,
        TGT_UROM   = 2'd2,
        TGT_RAM    = 2'd3
    } t_target;

    localparam logic [1:0] CFG_EXPANDED = 2'd0;
    localparam logic [1:0] CFG_ROM_MASK = 2'd1;
    localparam logic [1:0] CFG_SCREEN   = 2'd2;

    localparam logic [2:0] LAYOUT_FLAT      = 3'd0;
    localparam logic [2:0] LAYOUT_HIGH_EXT  = 3'd1;
    localparam logic [2:0] LAYOUT_ALL_EXT   = 3'd2;
    localparam logic [2:0] LAYOUT_SPLIT     = 3'd3;
    localparam logic [2:0] LAYOUT_MID_EXT0  = 3'd4;
    localparam logic [2:0] LAYOUT_MID_EXT1  = 3'd5;
    localparam logic [2:0] LAYOUT_MID_EXT2  = 3'd6;
    localparam logic [2:0] LAYOUT_MID_EXT3  = 3'd7;

    localparam logic [19:0] OFF_EXT_BASE = 20'h10000;
    localparam logic [19:0] OFF_SPLIT    = 20'h08000;
    localparam logic [19:0] OFF_EXT0     = 20'h0C000;
    localparam logic [19:0] OFF_EXT2     = 20'h14000;
    localparam logic [19:0] OFF_EXT3     = 20'h18000;

    localparam logic [1:0] WIN_LOWER = 2'd0;
    localparam logic [1:0] WIN_UPPER = 2'd3;

    typedef struct packed {
        t_cmd        command;
        logic [15:0] addr;
        logic [7:0]  wr_data;
        logic [7:0]  bank_byte;
        logic        lower_ram;
        logic        upper_ram;
        logic [7:0]  rom_choice;
    } t_in_item;

    typedef struct packed {
        t_target     target;
        logic [19:0] phys_addr;
        logic [2:0]  rom_index;
        logic        write_enable;
        logic [7:0]  data_out;
        logic        screen_write;
    } t_out_item;

    typedef struct packed {
        logic       expanded;
        logic [7:0] rom_mask;
        logic [1:0] screen_window;
    } t_cfg;

    // Classified operation handed from front to back.
    typedef struct packed {
        t_cmd        kind;
        logic [15:0] addr;
        logic [7:0]  wr_data;
        logic        screen_hit;
        logic [2:0]  layout;
        logic [2:0]  blk;
        logic        lower_ram;
        logic        upper_ram;
        logic [7:0]  rom_num;
    } t_op;

endpackage

[src/bsmm_queue.sv]
// Small first-in first-out queue of flip-flops, any width and depth.
// Depends on nothing.
module bsmm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, n_wp;
    logic [AW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign full      = (r_cnt == FULL_CNT);
    assign empty     = (r_cnt == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign o_rd_data = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

[src/bsmm_front.sv]
// Front end: decodes a command into a classified operation.
// Depends on bsmm_pkg.
module bsmm_front (
    input  bsmm_pkg::t_in_item i_item,
    input  bsmm_pkg::t_cfg     i_cfg,
    output bsmm_pkg::t_op      o_op
);

    always_comb begin
        o_op.kind       = i_item.command;
        o_op.addr       = i_item.addr;
        o_op.wr_data    = i_item.wr_data;
        o_op.screen_hit = (i_item.addr[15:14] == i_cfg.screen_window);
        o_op.layout     = i_item.bank_byte[2:0];
        o_op.blk        = i_cfg.expanded ? i_item.bank_byte[5:3] : 3'd0;
        o_op.lower_ram  = i_item.lower_ram;
        o_op.upper_ram  = i_item.upper_ram;
        o_op.rom_num    = i_item.rom_choice;
    end

endmodule

[src/bsmm_back.sv]
// Back end: holds the mapping state and resolves each operation.
// Depends on bsmm_pkg.
module bsmm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  bsmm_pkg::t_op       i_op,
    input  logic [7:0]          i_rom_mask,
    output bsmm_pkg::t_out_item o_result
);
    logic [19:0] r_win_off [4];
    logic        r_lower_is_ram;
    logic        r_upper_is_ram;
    logic [7:0]  r_rom_num;

    logic [19:0] n_win_off [4];
    logic [1:0]  win;
    logic [19:0] cur_off;
    logic [19:0] ram_addr;
    logic [19:0] blk_off;
    logic [19:0] ext_base;
    logic        rom_present;

    assign win      = i_op.addr[15:14];
    assign cur_off  = r_win_off[win];
    assign ram_addr = cur_off + {4'd0, i_op.addr};
    assign blk_off  = {1'b0, i_op.blk, 16'h0000};
    assign ext_base = bsmm_pkg::OFF_EXT_BASE + blk_off;

    assign rom_present = (r_rom_num[7:3] == 5'd0) && i_rom_mask[r_rom_num[2:0]];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_win_off[i] = '0;
        end
        case (i_op.layout)
            bsmm_pkg::LAYOUT_FLAT: begin
            end
            bsmm_pkg::LAYOUT_HIGH_EXT: begin
                n_win_off[3] = ext_base;
            end
            bsmm_pkg::LAYOUT_ALL_EXT: begin
                for (int i = 0; i < 4; i++) begin
                    n_win_off[i] = ext_base;
                end
            end
            bsmm_pkg::LAYOUT_SPLIT: begin
                n_win_off[1] = bsmm_pkg::OFF_SPLIT;
                n_win_off[3] = ext_base;
            end
            bsmm_pkg::LAYOUT_MID_EXT0: n_win_off[1] = bsmm_pkg::OFF_EXT0 + blk_off;
            bsmm_pkg::LAYOUT_MID_EXT1: n_win_off[1] = ext_base;
            bsmm_pkg::LAYOUT_MID_EXT2: n_win_off[1] = bsmm_pkg::OFF_EXT2 + blk_off;
            bsmm_pkg::LAYOUT_MID_EXT3: n_win_off[1] = bsmm_pkg::OFF_EXT3 + blk_off;
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        o_result.target = bsmm_pkg::TGT_NONE;
        case (i_op.kind)
            bsmm_pkg::CMD_READ: begin
                if (win == bsmm_pkg::WIN_LOWER && !r_lower_is_ram) begin
                    o_result.target    = bsmm_pkg::TGT_SYSROM;
                    o_result.phys_addr = {6'd0, i_op.addr[13:0]};
                end else if (win == bsmm_pkg::WIN_UPPER && !r_upper_is_ram) begin
                    o_result.target    = bsmm_pkg::TGT_UROM;
                    o_result.phys_addr = {6'd0, i_op.addr[13:0]};
                    o_result.rom_index = rom_present ? r_rom_num[2:0] : 3'd0;
                end else begin
                    o_result.target    = bsmm_pkg::TGT_RAM;
                    o_result.phys_addr = ram_addr;
                end
            end
            bsmm_pkg::CMD_WRITE: begin
                o_result.target       = bsmm_pkg::TGT_RAM;
                o_result.phys_addr    = ram_addr;
                o_result.write_enable = 1'b1;
                o_result.data_out     = i_op.wr_data;
                o_result.screen_write = i_op.screen_hit && (cur_off == '0);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_win_off[i] <= '0;
            end
            r_lower_is_ram <= 1'b0;
            r_upper_is_ram <= 1'b0;
            r_rom_num      <= '0;
        end else if (i_fire) begin
            if (i_op.kind == bsmm_pkg::CMD_BANK) begin
                for (int i = 0; i < 4; i++) begin
                    r_win_off[i] <= n_win_off[i];
                end
            end
            if (i_op.kind == bsmm_pkg::CMD_ROM) begin
                r_lower_is_ram <= i_op.lower_ram;
                r_upper_is_ram <= i_op.upper_ram;
                r_rom_num      <= i_op.rom_num;
            end
        end
    end

endmodule

[src/bank_switched_memory_mapper.sv]
// Bank-switched memory mapper, top level: config registers, front end,
// operation queue, back end and result queue.
// Depends on bsmm_pkg, bsmm_front, bsmm_queue, bsmm_back and assert_macros.svh.
//
// Takes one command per cycle while the operation queue is not full, and
// returns one result per command, in order. A command is registered in the
// operation queue, then resolved by the back end as it enters the result queue.
// The back end updates the window offsets in the cycle it retires a bank select,
// so each following access sees it with no bubble. Config writes are always
// taken and must only happen while no command is in flight.
`include "assert_macros.svh"

module bank_switched_memory_mapper #(
    parameter int OP_DEPTH  = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  bsmm_pkg::t_in_item  i_in_item,
    output logic                empty,
    input  logic                pop,
    output bsmm_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data
);
    localparam int OP_W  = $bits(bsmm_pkg::t_op);
    localparam int RES_W = $bits(bsmm_pkg::t_out_item);

    bsmm_pkg::t_cfg      r_cfg;
    bsmm_pkg::t_op       front_op;
    bsmm_pkg::t_op       back_op;
    bsmm_pkg::t_out_item back_res;
    logic                op_empty;
    logic                res_full;
    logic                back_fire;
    logic [OP_W-1:0]     op_rd;
    logic [RES_W-1:0]    res_rd;
    logic                out_we;
    logic                out_scr;
    logic                out_none;
    logic                out_zero;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expanded      <= 1'b0;
            r_cfg.rom_mask      <= 8'h01;
            r_cfg.screen_window <= 2'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                bsmm_pkg::CFG_EXPANDED: r_cfg.expanded      <= i_cfg_data[0];
                bsmm_pkg::CFG_ROM_MASK: r_cfg.rom_mask      <= i_cfg_data;
                bsmm_pkg::CFG_SCREEN:   r_cfg.screen_window <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    bsmm_front u_front (
        .i_item (i_in_item),
        .i_cfg  (r_cfg),
        .o_op   (front_op)
    );

    bsmm_queue #(
        .WIDTH (OP_W),
        .DEPTH (OP_DEPTH)
    ) u_op_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_wr_data (front_op),
        .full      (full),
        .pop       (back_fire),
        .o_rd_data (op_rd),
        .empty     (op_empty)
    );

    assign back_op   = bsmm_pkg::t_op'(op_rd);
    assign back_fire = !op_empty && !res_full;

    bsmm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (back_fire),
        .i_op       (back_op),
        .i_rom_mask (r_cfg.rom_mask),
        .o_result   (back_res)
    );

    bsmm_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (back_fire),
        .i_wr_data (back_res),
        .full      (res_full),
        .pop       (pop),
        .o_rd_data (res_rd),
        .empty     (empty)
    );

    assign o_out_item = bsmm_pkg::t_out_item'(res_rd);

    assign out_we   = !empty && o_out_item.write_enable;
    assign out_scr  = !empty && o_out_item.screen_write;
    assign out_none = !empty && (o_out_item.target == bsmm_pkg::TGT_NONE);
    assign out_zero = (o_out_item.phys_addr == '0) && (o_out_item.data_out == '0);

    `ASSERT_IMP(a_we_is_ram, i_clk, i_rst_n, out_we, o_out_item.target == bsmm_pkg::TGT_RAM)
    `ASSERT_IMP(a_scr_is_write, i_clk, i_rst_n, out_scr, o_out_item.write_enable)
    `ASSERT_IMP(a_none_is_zero, i_clk, i_rst_n, out_none, out_zero)
    `ASSERT_NXT(a_retire_fills, i_clk, i_rst_n, back_fire, !empty)

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for bank_switched_memory_mapper: random and directed
// commands, predicted in order and compared field by field on every transfer.
// Depends on bsmm_pkg and the RTL of the mapper.
module testbench;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 220;
    localparam int IN_W = $bits(bsmm_pkg::t_in_item);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    bsmm_pkg::t_in_item  i_in_item = '0;
    logic                empty;
    logic                pop = 1'b0;
    bsmm_pkg::t_out_item o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [1:0]          i_cfg_index = '0;
    logic [7:0]          i_cfg_data = '0;

    bsmm_pkg::t_in_item  pending_cmds[$];
    bsmm_pkg::t_out_item expected_results[$];

    logic [19:0] win_base[4];
    logic        map_lower_ram;
    logic        map_upper_ram;
    logic [7:0]  sel_rom;
    logic        cfg_expanded;
    logic [7:0]  cfg_rom_mask;
    logic [1:0]  cfg_screen_win;

    int  errors = 0;
    int  stall_cycles = 0;
    int  hold_cnt = 0;
    bit  hold_req = 0;
    bit  quiet = 0;

    bank_switched_memory_mapper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic bsmm_pkg::t_out_item map_access(input bsmm_pkg::t_in_item it);
        bsmm_pkg::t_out_item r;
        logic [1:0]          win;
        logic [19:0]         blk;
        logic                present;
        int                  k;
        r = '0;
        win = it.addr[15:14];
        case (it.command)
            bsmm_pkg::CMD_READ: begin
                if (win == bsmm_pkg::WIN_LOWER && !map_lower_ram) begin
                    r.target = bsmm_pkg::TGT_SYSROM;
                    r.phys_addr = {6'd0, it.addr[13:0]};
                end else if (win == bsmm_pkg::WIN_UPPER && !map_upper_ram) begin
                    present = (sel_rom < 8) && cfg_rom_mask[sel_rom[2:0]];
                    r.target = bsmm_pkg::TGT_UROM;
                    r.phys_addr = {6'd0, it.addr[13:0]};
                    r.rom_index = present ? sel_rom[2:0] : 3'd0;
                end else begin
                    r.target = bsmm_pkg::TGT_RAM;
                    r.phys_addr = win_base[win] + {4'd0, it.addr};
                end
            end
            bsmm_pkg::CMD_WRITE: begin
                r.target = bsmm_pkg::TGT_RAM;
                r.phys_addr = win_base[win] + {4'd0, it.addr};
                r.write_enable = 1'b1;
                r.data_out = it.wr_data;
                r.screen_write = (win == cfg_screen_win) &&
                                 (win_base[cfg_screen_win] == '0);
            end
            bsmm_pkg::CMD_BANK: begin
                blk = cfg_expanded ? {1'b0, it.bank_byte[5:3], 16'h0} : 20'h0;
                for (k = 0; k < 4; k++) win_base[k] = '0;
                case (it.bank_byte[2:0])
                    bsmm_pkg::LAYOUT_HIGH_EXT: win_base[3] = bsmm_pkg::OFF_EXT_BASE + blk;
                    bsmm_pkg::LAYOUT_ALL_EXT: begin
                        for (k = 0; k < 4; k++) win_base[k] = bsmm_pkg::OFF_EXT_BASE + blk;
                    end
                    bsmm_pkg::LAYOUT_SPLIT: begin
                        win_base[1] = bsmm_pkg::OFF_SPLIT;
                        win_base[3] = bsmm_pkg::OFF_EXT_BASE + blk;
                    end
                    bsmm_pkg::LAYOUT_MID_EXT0: win_base[1] = bsmm_pkg::OFF_EXT0 + blk;
                    bsmm_pkg::LAYOUT_MID_EXT1: win_base[1] = bsmm_pkg::OFF_EXT_BASE + blk;
                    bsmm_pkg::LAYOUT_MID_EXT2: win_base[1] = bsmm_pkg::OFF_EXT2 + blk;
                    bsmm_pkg::LAYOUT_MID_EXT3: win_base[1] = bsmm_pkg::OFF_EXT3 + blk;
                    default: ;
                endcase
            end
            default: begin
                map_lower_ram = it.lower_ram;
                map_upper_ram = it.upper_ram;
                sel_rom = it.rom_choice;
            end
        endcase
        return r;
    endfunction

    task automatic add_cmd(input bsmm_pkg::t_cmd c, input logic [15:0] a,
                           input logic [7:0] d, input logic [7:0] b,
                           input logic lr, input logic ur,
                           input logic [7:0] rc);
        bsmm_pkg::t_in_item it;
        it.command = c;
        it.addr = a;
        it.wr_data = d;
        it.bank_byte = b;
        it.lower_ram = lr;
        it.upper_ram = ur;
        it.rom_choice = rc;
        pending_cmds.push_back(it);
    endtask

    function automatic bsmm_pkg::t_in_item rand_cmd();
        bsmm_pkg::t_in_item it;
        logic [63:0]        raw;
        int                 pick;
        raw = {$urandom, $urandom};
        it = bsmm_pkg::t_in_item'(raw[IN_W-1:0]);
        pick = $urandom_range(99);
        if (pick < 40) it.command = bsmm_pkg::CMD_READ;
        else if (pick < 75) it.command = bsmm_pkg::CMD_WRITE;
        else if (pick < 87) it.command = bsmm_pkg::CMD_BANK;
        else it.command = bsmm_pkg::CMD_ROM;
        if ($urandom_range(3) != 0) it.rom_choice = 8'($urandom_range(9));
        return it;
    endfunction

    task automatic report(input string field, input logic [19:0] e, input logic [19:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, field, e, a);
        end
    endtask

    // Driver: present the oldest pending command.
    always @(negedge i_clk) begin
        push <= i_rst_n && pending_cmds.size() != 0 && (quiet || $urandom_range(99) >= 25);
        i_in_item <= pending_cmds.size() != 0 ? pending_cmds[0] : '0;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) hold_cnt--;
        pop <= i_rst_n && hold_cnt == 0 && (quiet || $urandom_range(99) >= 25);
    end

    // Monitor: check results, record input transfers, watch for a hang.
    always @(posedge i_clk) begin
        bsmm_pkg::t_out_item e;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result expected none actual %p", $time, o_out_item);
            end else begin
                e = expected_results.pop_front();
                report("target", 20'(e.target), 20'(o_out_item.target));
                report("phys_addr", e.phys_addr, o_out_item.phys_addr);
                report("rom_index", 20'(e.rom_index), 20'(o_out_item.rom_index));
                report("write_enable", 20'(e.write_enable), 20'(o_out_item.write_enable));
                report("data_out", 20'(e.data_out), 20'(o_out_item.data_out));
                report("screen_write", 20'(e.screen_write), 20'(o_out_item.screen_write));
            end
        end
        if (i_rst_n && push && !full)
            expected_results.push_back(map_access(pending_cmds.pop_front()));
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_config(input logic ex, input logic [7:0] mask, input logic [1:0] scr);
        logic [1:0] idx[3];
        logic [7:0] val[3];
        int         k;
        idx[0] = bsmm_pkg::CFG_EXPANDED;
        idx[1] = bsmm_pkg::CFG_ROM_MASK;
        idx[2] = bsmm_pkg::CFG_SCREEN;
        val[0] = {7'd0, ex};
        val[1] = mask;
        val[2] = {6'd0, scr};
        for (k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[k])
                bsmm_pkg::CFG_EXPANDED: cfg_expanded = val[k][0];
                bsmm_pkg::CFG_ROM_MASK: cfg_rom_mask = val[k];
                default: cfg_screen_win = val[k][1:0];
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_random(input int n);
        repeat (n) pending_cmds.push_back(rand_cmd());
    endtask

    initial begin
        int k;
        for (k = 0; k < 4; k++) win_base[k] = '0;
        map_lower_ram = 1'b0;
        map_upper_ram = 1'b0;
        sel_rom = '0;
        cfg_expanded = 1'b0;
        cfg_rom_mask = 8'h01;
        cfg_screen_win = 2'd3;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_cmd(bsmm_pkg::CMD_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_READ,  16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF);
        add_cmd(bsmm_pkg::CMD_READ,  16'h7FFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_WRITE, 16'h0000, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_WRITE, 16'hC000, 8'h5A, 8'hFF, 1'b1, 1'b1, 8'hFF);
        add_cmd(bsmm_pkg::CMD_WRITE, 16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_BANK,  16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF);
        add_cmd(bsmm_pkg::CMD_READ,  16'h7FFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_WRITE, 16'h4000, 8'hA5, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_BANK,  16'h0000, 8'h00, 8'hC2, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_WRITE, 16'hC000, 8'h11, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_BANK,  16'h0000, 8'h00, 8'h3B, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_WRITE, 16'hFFFF, 8'h22, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_ROM,   16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF);
        add_cmd(bsmm_pkg::CMD_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_READ,  16'hFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_ROM,   16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h09);
        add_cmd(bsmm_pkg::CMD_READ,  16'hC123, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_ROM,   16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_READ,  16'hC123, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_BANK,  16'h0000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00);
        add_cmd(bsmm_pkg::CMD_WRITE, 16'hC000, 8'h80, 8'h00, 1'b0, 1'b0, 8'h00);
        add_random(PHASE_ITEMS - 30);
        drain();

        @(negedge i_clk);
        write_config(1'b1, 8'hFF, 2'd0);
        add_random(PHASE_ITEMS);
        drain();

        hold_req = 1;
        @(negedge i_clk);
        write_config(1'b0, 8'h00, 2'd3);
        add_random(PHASE_ITEMS);
        drain();

        quiet = 1;
        @(negedge i_clk);
        write_config(1'b1, 8'($urandom), 2'd1);
        add_random(PHASE_ITEMS);
        drain();

        quiet = 0;
        @(negedge i_clk);
        write_config(1'b1, 8'($urandom), 2'd2);
        add_random(PHASE_ITEMS);
        drain();

        @(negedge i_clk);
        write_config(1'b0, 8'hA5, 2'd3);
        add_random(PHASE_ITEMS);
        drain();

        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
